// ----- design/hpu_pkg.sv -----
// Shared types, operation codes and reset constants for the handheld palette unit.
// Used by hpu_ctrl, hpu_datapath and handheld_palette_unit. No dependencies.
`default_nettype none

package hpu_pkg;

    // Operation codes carried in the operation field of an input beat.
    localparam logic [3:0] OP_WRITE_BGP  = 4'd0;
    localparam logic [3:0] OP_WRITE_OBP0 = 4'd1;
    localparam logic [3:0] OP_WRITE_OBP1 = 4'd2;
    localparam logic [3:0] OP_WRITE_BCPS = 4'd3;
    localparam logic [3:0] OP_WRITE_BCPD = 4'd4;
    localparam logic [3:0] OP_WRITE_OCPS = 4'd5;
    localparam logic [3:0] OP_WRITE_OCPD = 4'd6;
    localparam logic [3:0] OP_MONO_BG    = 4'd7;
    localparam logic [3:0] OP_MONO_OBJ   = 4'd8;
    localparam logic [3:0] OP_COLOR_BG   = 4'd9;
    localparam logic [3:0] OP_COLOR_OBJ  = 4'd10;

    // Configuration register indexes.
    localparam logic [3:0] CFG_SHADE_0 = 4'd0;
    localparam logic [3:0] CFG_SHADE_1 = 4'd1;
    localparam logic [3:0] CFG_SHADE_2 = 4'd2;
    localparam logic [3:0] CFG_SHADE_3 = 4'd3;

    localparam int OP_W      = 4;
    localparam int DATA_W    = 8;
    localparam int CID_W     = 2;
    localparam int PSEL_W    = 3;
    localparam int RGBA_W    = 32;
    localparam int CFG_IDX_W = 4;
    localparam int RAM_DEPTH = 64;
    localparam int RAM_AW    = 6;

    localparam logic [RGBA_W-1:0] SHADE_0_RST = 32'hFFFF_FFFF;
    localparam logic [RGBA_W-1:0] SHADE_1_RST = 32'hAAAA_AAFF;
    localparam logic [RGBA_W-1:0] SHADE_2_RST = 32'h5555_55FF;
    localparam logic [RGBA_W-1:0] SHADE_3_RST = 32'h0000_00FF;
    localparam logic [DATA_W-1:0] BGP_RST     = 8'hFC;
    localparam logic [DATA_W-1:0] RAM_RST     = 8'hFF;
    localparam logic [7:0]        ALPHA_OPAQUE = 8'hFF;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_item;   // capture the accepted input beat
        logic exec_write;  // apply a register or color RAM write
        logic exec_read;   // read the palette state for a resolve
        logic load_out;    // load the formatted color into the output register
    } hpu_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_resolve;  // the captured operation produces a result
    } hpu_status_t;

    // Widen a 5-bit color channel to 8 bits by repeating its top bits.
    function automatic logic [7:0] expand5(input logic [4:0] c);
        expand5 = {c, c[4:2]};
    endfunction

endpackage

`default_nettype wire

// ----- design/handheld_palette_unit.sv -----
// Top level of the handheld palette unit: binds the controller and datapath.
// Depends on hpu_pkg, hpu_ctrl and hpu_datapath.
`default_nettype none

// The palette unit keeps the three monochrome palettes, the background and
// sprite color RAMs (64 bytes each) with their index registers, and four
// shade registers on the configuration port. Each input beat is one
// operation: a write updates palette state and returns nothing, a resolve
// returns one 32-bit RGBA color on the result channel. An item is handled
// in a sequence of states set by the controller: the accept cycle captures
// the beat, the next cycle applies a write or reads the palette state (the
// color RAM read ports are registered), and a resolve then formats the color
// into the output register in the format state. A resolve whose result
// finds the previous result still untaken waits in the format step until
// the result channel takes it. The next beat is accepted while a finished
// result is waiting. Color RAM bytes read as 0xFF until written, tracked
// with one flag per byte, so no clearing pass is needed after reset. The
// configuration port is always ready; writes to indexes beyond the four
// shade registers are dropped.
module handheld_palette_unit
    import hpu_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [OP_W-1:0]      s_operation,
    input  wire logic [DATA_W-1:0]    s_write_data,
    input  wire logic [CID_W-1:0]     s_color_id,
    input  wire logic [PSEL_W-1:0]    s_palette_select,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic [RGBA_W-1:0]         m_rgba_color,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [RGBA_W-1:0]    cfg_data
);

    hpu_cmd_t    cmd;
    hpu_status_t status;

    // Shade registers are written directly; every configuration beat is accepted.
    assign cfg_ready = 1'b1;

    hpu_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    hpu_datapath u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .status           (status),
        .s_operation      (s_operation),
        .s_write_data     (s_write_data),
        .s_color_id       (s_color_id),
        .s_palette_select (s_palette_select),
        .cfg_wr           (cfg_valid && cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .m_rgba_color     (m_rgba_color)
    );

endmodule

`default_nettype wire

// ----- design/hpu_ctrl.sv -----
// Sequencing controller of the handheld palette unit: accept, execute, format.
// Depends on hpu_pkg for the command and status structs.
`default_nettype none

module hpu_ctrl
    import hpu_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    output logic             m_valid,
    input  wire logic        m_ready,
    input  wire hpu_status_t status,
    output hpu_cmd_t         cmd
);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_EXEC   = 3'b010,
        ST_FORMAT = 3'b100
    } hpu_state_t;

    hpu_state_t state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;

    assign out_free = !out_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = out_valid_reg;

    always_comb begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !m_ready;
        cmd            = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (status.is_resolve) begin
                    cmd.exec_read = 1'b1;
                    state_next    = ST_FORMAT;
                end else begin
                    cmd.exec_write = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_FORMAT: begin
                if (out_free) begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // A result is never loaded over one that has not been taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (!out_valid_reg || m_ready))
        else $error("output register overwritten while still held");

    // An accepted beat is always executed in the following cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_EXEC))
        else $error("accepted beat not executed");

    // A palette read is always followed by formatting, never a second read.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.exec_read |=> (state_reg == ST_FORMAT && !cmd.exec_read))
        else $error("resolve read not followed by format");

    // At most one command is issued per cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.load_item, cmd.exec_write, cmd.exec_read, cmd.load_out}))
        else $error("conflicting commands issued");

endmodule

`default_nettype wire

// ----- design/hpu_datapath.sv -----
// Datapath of the handheld palette unit: palette registers, color RAMs,
// shade registers and the output register. Depends on hpu_pkg.
`default_nettype none

module hpu_datapath
    import hpu_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire hpu_cmd_t             cmd,
    output hpu_status_t               status,
    input  wire logic [OP_W-1:0]      s_operation,
    input  wire logic [DATA_W-1:0]    s_write_data,
    input  wire logic [CID_W-1:0]     s_color_id,
    input  wire logic [PSEL_W-1:0]    s_palette_select,
    input  wire logic                 cfg_wr,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [RGBA_W-1:0]    cfg_data,
    output logic [RGBA_W-1:0]         m_rgba_color
);

    // Captured input beat.
    logic [OP_W-1:0]   op_reg;
    logic [DATA_W-1:0] data_reg;
    logic [CID_W-1:0]  cid_reg;
    logic [PSEL_W-1:0] psel_reg;

    // Architectural palette state.
    logic [RGBA_W-1:0] shade_reg [4];
    logic [DATA_W-1:0] bgp_reg, obp0_reg, obp1_reg;
    logic [DATA_W-1:0] bg_idx_reg, obj_idx_reg, bg_idx_next, obj_idx_next;

    // Color RAMs with per-byte written flags; an unwritten byte reads as 0xFF.
    logic [DATA_W-1:0]    bg_mem  [RAM_DEPTH];
    logic [DATA_W-1:0]    obj_mem [RAM_DEPTH];
    logic [RAM_DEPTH-1:0] bg_vld_reg, obj_vld_reg;

    // Read stage results.
    logic [DATA_W-1:0] bg_lo_reg, bg_hi_reg, obj_lo_reg, obj_hi_reg;
    logic              lo_vld_reg, hi_vld_reg;
    logic              is_color_reg, is_obj_reg;
    logic [1:0]        shade_idx_reg;

    logic [RAM_AW-1:0] addr_lo, addr_hi;
    logic [DATA_W-1:0] mono_pal;
    logic [1:0]        shade_idx;
    logic [DATA_W-1:0] lo_byte, hi_byte;
    logic [RGBA_W-1:0] color_rgba, result;
    logic              bg_wr, obj_wr;

    assign status.is_resolve = (op_reg == OP_MONO_BG) || (op_reg == OP_MONO_OBJ) ||
                               (op_reg == OP_COLOR_BG) || (op_reg == OP_COLOR_OBJ);

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            op_reg   <= s_operation;
            data_reg <= s_write_data;
            cid_reg  <= s_color_id;
            psel_reg <= s_palette_select;
        end
    end

    // Each color occupies two bytes; eight bytes per palette.
    assign addr_lo = {psel_reg, cid_reg, 1'b0};
    assign addr_hi = {psel_reg, cid_reg, 1'b1};

    assign bg_wr  = cmd.exec_write && (op_reg == OP_WRITE_BCPD);
    assign obj_wr = cmd.exec_write && (op_reg == OP_WRITE_OCPD);

    // Auto-increment wraps within the low six bits and keeps bits 7..6.
    always_comb begin
        bg_idx_next  = bg_idx_reg;
        obj_idx_next = obj_idx_reg;
        if (cmd.exec_write) begin
            case (op_reg)
                OP_WRITE_BCPS: bg_idx_next = data_reg;
                OP_WRITE_OCPS: obj_idx_next = data_reg;
                OP_WRITE_BCPD: begin
                    if (bg_idx_reg[7]) begin
                        bg_idx_next = {bg_idx_reg[7:6], bg_idx_reg[5:0] + 6'd1};
                    end
                end
                OP_WRITE_OCPD: begin
                    if (obj_idx_reg[7]) begin
                        obj_idx_next = {obj_idx_reg[7:6], obj_idx_reg[5:0] + 6'd1};
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shade_reg[0] <= SHADE_0_RST;
            shade_reg[1] <= SHADE_1_RST;
            shade_reg[2] <= SHADE_2_RST;
            shade_reg[3] <= SHADE_3_RST;
            bgp_reg      <= BGP_RST;
            obp0_reg     <= '0;
            obp1_reg     <= '0;
            bg_idx_reg   <= '0;
            obj_idx_reg  <= '0;
            bg_vld_reg   <= '0;
            obj_vld_reg  <= '0;
        end else begin
            if (cfg_wr) begin
                case (cfg_index)
                    CFG_SHADE_0: shade_reg[0] <= cfg_data;
                    CFG_SHADE_1: shade_reg[1] <= cfg_data;
                    CFG_SHADE_2: shade_reg[2] <= cfg_data;
                    CFG_SHADE_3: shade_reg[3] <= cfg_data;
                    default: begin
                    end
                endcase
            end
            if (cmd.exec_write) begin
                case (op_reg)
                    OP_WRITE_BGP:  bgp_reg  <= data_reg;
                    OP_WRITE_OBP0: obp0_reg <= data_reg;
                    OP_WRITE_OBP1: obp1_reg <= data_reg;
                    default: begin
                    end
                endcase
            end
            bg_idx_reg  <= bg_idx_next;
            obj_idx_reg <= obj_idx_next;
            if (bg_wr) begin
                bg_vld_reg[bg_idx_reg[RAM_AW-1:0]] <= 1'b1;
            end
            if (obj_wr) begin
                obj_vld_reg[obj_idx_reg[RAM_AW-1:0]] <= 1'b1;
            end
        end
    end

    // Background color RAM: one write port, two registered read ports.
    always_ff @(posedge aclk) begin
        if (bg_wr) begin
            bg_mem[bg_idx_reg[RAM_AW-1:0]] <= data_reg;
        end
        if (cmd.exec_read) begin
            bg_lo_reg <= bg_mem[addr_lo];
            bg_hi_reg <= bg_mem[addr_hi];
        end
    end

    // Sprite color RAM.
    always_ff @(posedge aclk) begin
        if (obj_wr) begin
            obj_mem[obj_idx_reg[RAM_AW-1:0]] <= data_reg;
        end
        if (cmd.exec_read) begin
            obj_lo_reg <= obj_mem[addr_lo];
            obj_hi_reg <= obj_mem[addr_hi];
        end
    end

    // Monochrome shade selection.
    always_comb begin
        if (op_reg == OP_MONO_BG) begin
            mono_pal = bgp_reg;
        end else if (psel_reg == '0) begin
            mono_pal = obp0_reg;
        end else begin
            mono_pal = obp1_reg;
        end
        case (cid_reg)
            2'd0:    shade_idx = mono_pal[1:0];
            2'd1:    shade_idx = mono_pal[3:2];
            2'd2:    shade_idx = mono_pal[5:4];
            2'd3:    shade_idx = mono_pal[7:6];
            default: shade_idx = mono_pal[1:0];
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec_read) begin
            is_color_reg  <= (op_reg == OP_COLOR_BG) || (op_reg == OP_COLOR_OBJ);
            is_obj_reg    <= (op_reg == OP_COLOR_OBJ);
            shade_idx_reg <= shade_idx;
            if (op_reg == OP_COLOR_OBJ) begin
                lo_vld_reg <= obj_vld_reg[addr_lo];
                hi_vld_reg <= obj_vld_reg[addr_hi];
            end else begin
                lo_vld_reg <= bg_vld_reg[addr_lo];
                hi_vld_reg <= bg_vld_reg[addr_hi];
            end
        end
    end

    // Format the 15-bit color into RGBA.
    always_comb begin
        lo_byte = is_obj_reg ? obj_lo_reg : bg_lo_reg;
        hi_byte = is_obj_reg ? obj_hi_reg : bg_hi_reg;
        if (!lo_vld_reg) begin
            lo_byte = RAM_RST;
        end
        if (!hi_vld_reg) begin
            hi_byte = RAM_RST;
        end
        color_rgba = {expand5(lo_byte[4:0]),
                      expand5({hi_byte[1:0], lo_byte[7:5]}),
                      expand5(hi_byte[6:2]),
                      ALPHA_OPAQUE};
        result = is_color_reg ? color_rgba : shade_reg[shade_idx_reg];
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_rgba_color <= result;
        end
    end

endmodule

`default_nettype wire

// ----- dv/tb_handheld_palette_unit.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for handheld_palette_unit: directed and random palette traffic.
// Depends on hpu_pkg and the handheld_palette_unit RTL; needs no other files.

module tb_handheld_palette_unit;
    import hpu_pkg::*;

    // Operation codes past the last resolve do nothing in the block.
    localparam logic [3:0] OP_FIRST_UNUSED = 4'd11;
    localparam logic [3:0] OP_LAST_CODE    = 4'd15;

    // Shade register indexes that do not exist; writes to them must be dropped.
    localparam logic [3:0] CFG_FIRST_MISSING = 4'd4;
    localparam logic [3:0] CFG_LAST_MISSING  = 4'd15;

    // SETTLE_CYCLES idle cycles after the last result let any trailing write land.
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_CYCLES  = 20;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_ITEMS  = 320;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [3:0]  s_operation = '0;
    logic [7:0]  s_write_data = '0;
    logic [1:0]  s_color_id = '0;
    logic [2:0]  s_palette_select = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_rgba_color;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [3:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    handheld_palette_unit uut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_operation      (s_operation),
        .s_write_data     (s_write_data),
        .s_color_id       (s_color_id),
        .s_palette_select (s_palette_select),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_rgba_color     (m_rgba_color),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Predicted palette state. It follows every accepted beat and every
    // accepted configuration write, in the order the block sees them.
    logic [31:0] pred_shade [4];
    logic [7:0]  pred_bgp;
    logic [7:0]  pred_obp0;
    logic [7:0]  pred_obp1;
    logic [7:0]  pred_bcps;
    logic [7:0]  pred_ocps;
    logic [7:0]  pred_bg_cram  [64];
    logic [7:0]  pred_obj_cram [64];

    // Colors still owed by the block, oldest first.
    logic [31:0] rgba_expect_q [$];

    int          error_count = 0;
    int unsigned cycle_count = 0;
    int          burst_left = 0;
    bit          tx_gaps_on = 1'b1;
    int          rx_mode = 0;
    int          rx_phase_left = 0;
    logic [31:0] rgba_due;

    // Pick the two-bit shade for a pixel out of a monochrome palette byte
    // and turn it into the RGBA value of that shade.
    function automatic logic [31:0] mono_shade_color(input logic [7:0] pal,
                                                     input logic [1:0] cid);
        logic [1:0] shade;
        shade = pal[2*cid +: 2];
        return pred_shade[shade];
    endfunction

    // A 5-bit channel becomes 8 bits by copying its top three bits below it.
    function automatic logic [7:0] stretch_channel(input logic [4:0] c);
        return {c, c[4:2]};
    endfunction

    // Each palette holds four colors of two bytes each, little-endian RGB555.
    function automatic logic [31:0] cram_color(input logic [7:0] lo, input logic [7:0] hi);
        logic [4:0] red5;
        logic [4:0] green5;
        logic [4:0] blue5;
        red5   = lo[4:0];
        green5 = {hi[1:0], lo[7:5]};
        blue5  = hi[6:2];
        return {stretch_channel(red5), stretch_channel(green5), stretch_channel(blue5),
                ALPHA_OPAQUE};
    endfunction

    // Apply one accepted beat to the predicted state; queue a color for resolves.
    task automatic predict_palette_op(input logic [3:0] op, input logic [7:0] data,
                                      input logic [1:0] cid, input logic [2:0] psel);
        logic [5:0] slot;
        logic [5:0] base;
        base = {psel, cid, 1'b0};
        case (op)
            OP_WRITE_BGP:  pred_bgp  = data;
            OP_WRITE_OBP0: pred_obp0 = data;
            OP_WRITE_OBP1: pred_obp1 = data;
            OP_WRITE_BCPS: pred_bcps = data;
            OP_WRITE_OCPS: pred_ocps = data;
            OP_WRITE_BCPD: begin
                slot = pred_bcps[5:0];
                pred_bg_cram[slot] = data;
                // Auto-increment only touches the low six bits; bits 7..6 stay.
                if (pred_bcps[7]) pred_bcps[5:0] = slot + 6'd1;
            end
            OP_WRITE_OCPD: begin
                slot = pred_ocps[5:0];
                pred_obj_cram[slot] = data;
                if (pred_ocps[7]) pred_ocps[5:0] = slot + 6'd1;
            end
            OP_MONO_BG:
                rgba_expect_q.push_back(mono_shade_color(pred_bgp, cid));
            OP_MONO_OBJ:
                rgba_expect_q.push_back(mono_shade_color(psel == 3'd0 ? pred_obp0 : pred_obp1,
                                                         cid));
            OP_COLOR_BG:
                rgba_expect_q.push_back(cram_color(pred_bg_cram[base],
                                                   pred_bg_cram[base + 6'd1]));
            OP_COLOR_OBJ:
                rgba_expect_q.push_back(cram_color(pred_obj_cram[base],
                                                   pred_obj_cram[base + 6'd1]));
            default: ;
        endcase
    endtask

    // Present one beat and hold it until the block takes it. Beats go out in
    // bursts; a random gap is only inserted between bursts, and valid is never
    // dropped between two beats of the same burst.
    task automatic send_beat(input logic [3:0] op, input logic [7:0] data,
                             input logic [1:0] cid, input logic [2:0] psel);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = tx_gaps_on ? $urandom_range(0, 6) : 0;
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid          <= 1'b1;
        s_operation      <= op;
        s_write_data     <= data;
        s_color_id       <= cid;
        s_palette_select <= psel;
        do @(posedge aclk); while (!(s_valid && s_ready));
        predict_palette_op(op, data, cid, psel);
    endtask

    // Stop sending, wait for every owed color, then let trailing writes finish.
    task automatic settle_pipeline();
        s_valid <= 1'b0;
        burst_left = 0;
        while (rgba_expect_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Leaves cfg_valid high so back-to-back writes need no second assignment
    // in the same step; program_shades lowers it after the last one.
    task automatic write_shade(input logic [3:0] idx, input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
        if (idx <= CFG_SHADE_3) pred_shade[idx[1:0]] = value;
    endtask

    // Load all four shades, with one write to a missing register in the middle
    // that must leave them alone. Only called with the block idle.
    task automatic program_shades(input logic [31:0] v0, input logic [31:0] v1,
                                  input logic [31:0] v2, input logic [31:0] v3,
                                  input logic [3:0] missing_idx,
                                  input logic [31:0] missing_val);
        write_shade(CFG_SHADE_0, v0);
        write_shade(CFG_SHADE_1, v1);
        write_shade(missing_idx, missing_val);
        write_shade(CFG_SHADE_2, v2);
        write_shade(CFG_SHADE_3, v3);
        cfg_valid <= 1'b0;
    endtask

    // 0xE4 maps color id n to shade n, so four resolves show every shade register.
    task automatic check_all_shades();
        send_beat(OP_WRITE_BGP, 8'hE4, 2'd0, 3'd0);
        for (int i = 0; i < 4; i++) send_beat(OP_MONO_BG, 8'($urandom), 2'(i), 3'($urandom));
        send_beat(OP_MONO_OBJ, 8'($urandom), 2'($urandom), 3'd0);
    endtask

    task automatic test_reset_state();
        // BGP comes out of reset as 0xFC, the sprite palettes as zero and
        // every color RAM byte as 0xFF, which resolves to opaque white.
        send_beat(OP_MONO_BG,   8'h00, 2'd0, 3'd0);
        send_beat(OP_MONO_BG,   8'hFF, 2'd3, 3'd7);
        send_beat(OP_MONO_OBJ,  8'h00, 2'd1, 3'd0);
        send_beat(OP_COLOR_BG,  8'h00, 2'd0, 3'd0);
        send_beat(OP_COLOR_OBJ, 8'hFF, 2'd3, 3'd7);
    endtask

    task automatic test_index_autoincrement();
        // Start at index 63 with increment on: the second data write wraps to 0.
        send_beat(OP_WRITE_BCPS, 8'hBF, 2'd0, 3'd0);
        send_beat(OP_WRITE_BCPD, 8'h1F, 2'd0, 3'd0);
        send_beat(OP_WRITE_BCPD, 8'h00, 2'd0, 3'd0);
        // Increment off with bit 6 set: both writes land on byte 62.
        send_beat(OP_WRITE_BCPS, 8'h7E, 2'd0, 3'd0);
        send_beat(OP_WRITE_BCPD, 8'hE0, 2'd0, 3'd0);
        send_beat(OP_WRITE_BCPD, 8'h83, 2'd0, 3'd0);
        send_beat(OP_COLOR_BG,   8'h00, 2'd3, 3'd7);
        send_beat(OP_COLOR_BG,   8'h00, 2'd0, 3'd0);
        // Sprite RAM with both top index bits set; the high byte's bit 7 must be ignored.
        send_beat(OP_WRITE_OCPS, 8'hC0, 2'd0, 3'd0);
        send_beat(OP_WRITE_OCPD, 8'hFF, 2'd0, 3'd0);
        send_beat(OP_WRITE_OCPD, 8'hFC, 2'd0, 3'd0);
        send_beat(OP_COLOR_OBJ,  8'h00, 2'd0, 3'd0);
    endtask

    task automatic test_mono_palettes();
        send_beat(OP_WRITE_BGP,  8'h1B, 2'd0, 3'd0);
        send_beat(OP_WRITE_OBP0, 8'hE4, 2'd0, 3'd0);
        send_beat(OP_WRITE_OBP1, 8'h27, 2'd0, 3'd0);
        send_beat(OP_MONO_BG,    8'h00, 2'd2, 3'd0);
        send_beat(OP_MONO_OBJ,   8'h00, 2'd3, 3'd0);
        // Any nonzero palette number selects the second sprite palette.
        send_beat(OP_MONO_OBJ,   8'h00, 2'd0, 3'd4);
    endtask

    task automatic test_unused_operations();
        // Unused codes must neither change state nor produce a color.
        send_beat(OP_FIRST_UNUSED, 8'hFF, 2'd3, 3'd7);
        send_beat(OP_LAST_CODE,    8'h00, 2'd0, 3'd0);
        send_beat(OP_MONO_OBJ,     8'h00, 2'd2, 3'd0);
    endtask

    // Mostly well-formed traffic: resolves, monochrome palette writes and loads
    // through an auto-incrementing index, with single writes and unused codes mixed in.
    task automatic random_traffic(input int n_items);
        int         sent;
        int         pick;
        int         run_len;
        logic [3:0] sel_op;
        logic [3:0] data_op;
        sent = 0;
        while (sent < n_items) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                sel_op = OP_MONO_BG + 4'($urandom_range(0, 3));
                send_beat(sel_op, 8'($urandom), 2'($urandom), 3'($urandom));
                sent++;
            end else if (pick < 55) begin
                sel_op = OP_WRITE_BGP + 4'($urandom_range(0, 2));
                send_beat(sel_op, 8'($urandom), 2'($urandom), 3'($urandom));
                sent++;
            end else if (pick < 80) begin
                sel_op  = $urandom_range(0, 1) ? OP_WRITE_BCPS : OP_WRITE_OCPS;
                data_op = (sel_op == OP_WRITE_BCPS) ? OP_WRITE_BCPD : OP_WRITE_OCPD;
                run_len = $urandom_range(1, 16);
                send_beat(sel_op, {1'b1, 7'($urandom)}, 2'($urandom), 3'($urandom));
                repeat (run_len) send_beat(data_op, 8'($urandom), 2'($urandom), 3'($urandom));
                sent += run_len + 1;
            end else if (pick < 88) begin
                case ($urandom_range(0, 3))
                    0:       sel_op = OP_WRITE_BCPS;
                    1:       sel_op = OP_WRITE_BCPD;
                    2:       sel_op = OP_WRITE_OCPS;
                    default: sel_op = OP_WRITE_OCPD;
                endcase
                send_beat(sel_op, 8'($urandom), 2'($urandom), 3'($urandom));
                sent++;
            end else if (pick < 94) begin
                sel_op = 4'($urandom_range(OP_FIRST_UNUSED, OP_LAST_CODE));
                send_beat(sel_op, 8'($urandom), 2'($urandom), 3'($urandom));
            end else begin
                sel_op = 4'($urandom);
                send_beat(sel_op, 8'($urandom), 2'($urandom), 3'($urandom));
                if (sel_op < OP_FIRST_UNUSED) sent++;
            end
        end
    endtask

    // Free-running cycle count; also the hard stop if the run hangs.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // The result side switches among three behaviors: always ready, random
    // ready, and a fixed repeating pattern, mostly stalled, keyed to the cycle count.
    always @(posedge aclk) begin
        if (rx_phase_left == 0) begin
            rx_mode       <= $urandom_range(0, 2);
            rx_phase_left <= $urandom_range(50, 400);
        end else begin
            rx_phase_left <= rx_phase_left - 1;
        end
        case (rx_mode)
            0:       m_ready <= 1'b1;
            1:       m_ready <= 1'($urandom_range(0, 1));
            default: m_ready <= (cycle_count % 13) >= 9;
        endcase
    end

    // Every color taken from the block is compared with the oldest prediction.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (rgba_expect_q.size() == 0) begin
                $display("%0t: unexpected beat, expected none, actual rgba_color %h",
                         $time, m_rgba_color);
                error_count++;
            end else begin
                rgba_due = rgba_expect_q.pop_front();
                if (m_rgba_color !== rgba_due) begin
                    $display("%0t: rgba_color expected %h actual %h",
                             $time, rgba_due, m_rgba_color);
                    error_count++;
                end
            end
        end
    end

    initial begin
        pred_shade[0] = SHADE_0_RST;
        pred_shade[1] = SHADE_1_RST;
        pred_shade[2] = SHADE_2_RST;
        pred_shade[3] = SHADE_3_RST;
        pred_bgp  = BGP_RST;
        pred_obp0 = '0;
        pred_obp1 = '0;
        pred_bcps = '0;
        pred_ocps = '0;
        for (int i = 0; i < 64; i++) begin
            pred_bg_cram[i]  = RAM_RST;
            pred_obj_cram[i] = RAM_RST;
        end

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed checks run against the reset shade values.
        test_reset_state();
        test_index_autoincrement();
        test_mono_palettes();
        test_unused_operations();

        // All shades at zero; the missing register gets all ones and must be ignored.
        settle_pipeline();
        program_shades(32'h0, 32'h0, 32'h0, 32'h0, CFG_FIRST_MISSING, 32'hFFFF_FFFF);
        check_all_shades();
        random_traffic(RANDOM_ITEMS);

        // All shades at all ones, with the highest index written to zero.
        settle_pipeline();
        program_shades(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                       CFG_LAST_MISSING, 32'h0);
        check_all_shades();
        random_traffic(RANDOM_ITEMS);

        // Random shades, and the sender runs without gaps for this stretch.
        settle_pipeline();
        program_shades($urandom, $urandom, $urandom, $urandom,
                       4'($urandom_range(CFG_FIRST_MISSING, CFG_LAST_MISSING)), $urandom);
        tx_gaps_on = 1'b0;
        check_all_shades();
        random_traffic(RANDOM_ITEMS);
        tx_gaps_on = 1'b1;

        // Back to the reset shades for the last stretch.
        settle_pipeline();
        program_shades(SHADE_0_RST, SHADE_1_RST, SHADE_2_RST, SHADE_3_RST,
                       CFG_FIRST_MISSING, $urandom);
        check_all_shades();
        random_traffic(RANDOM_ITEMS);

        s_valid <= 1'b0;
        while (rgba_expect_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (error_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
